FILE: hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants
// Result record, kind codes, opcodes and queue sizing for the deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int LEN_BITS = 64;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [3:0] OP_CONT   = 4'd0;
	localparam logic [3:0] OP_TEXT   = 4'd1;
	localparam logic [3:0] OP_BINARY = 4'd2;
	localparam logic [3:0] OP_CLOSE  = 4'd8;
	localparam logic [3:0] OP_PING   = 4'd9;
	localparam logic [3:0] OP_PONG   = 4'd10;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_KEY     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_DROP    = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic [1:0] kind;
		logic [3:0] mk;
		logic       fe;
		logic       me;
	} res_t;

endpackage

FILE: hw/rtl/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front: header parser
// Walks the frame header, tracks length and key position, and emits one
// result record per payload byte, empty frame or opcode error.
// ----------------------------------------------------------------------------
module wsd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        in_byte,
	input  logic              restart,
	output logic              res_valid,
	output wsd_pkg::res_t     res
);

	wsd_pkg::phase_t                 phase_q, n_phase, eff_phase;
	logic [2:0]                      hcnt_q, n_hcnt;
	logic [wsd_pkg::LEN_BITS-1:0]    len_q, n_len;
	logic [1:0]                      pos_q, n_pos;
	logic [31:0]                     key_q, n_key;
	logic                            mask_q, n_mask;
	logic                            fin_q, n_fin;
	logic [3:0]                      mop_q, n_mop;
	logic                            go_len, go_pay, last;
	logic [7:0]                      kb;
	logic [3:0]                      op;

	always_comb begin
		n_phase   = phase_q;
		n_hcnt    = hcnt_q;
		n_len     = len_q;
		n_pos     = pos_q;
		n_key     = key_q;
		n_mask    = mask_q;
		n_fin     = fin_q;
		n_mop     = mop_q;
		go_len    = 1'b0;
		go_pay    = 1'b0;
		last      = 1'b0;
		kb        = 8'd0;
		op        = in_byte[3:0];
		res_valid = 1'b0;
		res       = '0;
		eff_phase = restart ? wsd_pkg::PH_HDR0 : phase_q;

		unique case (eff_phase)
			wsd_pkg::PH_HDR1: begin
				n_mask = in_byte[7];
				n_key  = 32'd0;
				n_len  = '0;
				if (in_byte[6:0] == wsd_pkg::LEN_EXT16) begin
					n_phase = wsd_pkg::PH_EXTLEN;
					n_hcnt  = 3'd1;
				end else if (in_byte[6:0] == wsd_pkg::LEN_EXT64) begin
					n_phase = wsd_pkg::PH_EXTLEN;
					n_hcnt  = 3'd7;
				end else begin
					n_len  = wsd_pkg::LEN_BITS'(in_byte[6:0]);
					go_len = 1'b1;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				n_len = {len_q[wsd_pkg::LEN_BITS-9:0], in_byte};
				if (hcnt_q != 3'd0) begin
					n_hcnt = hcnt_q - 3'd1;
				end else begin
					go_len = 1'b1;
				end
			end
			wsd_pkg::PH_KEY: begin
				n_key = {key_q[23:0], in_byte};
				if (hcnt_q != 3'd0) begin
					n_hcnt = hcnt_q - 3'd1;
				end else begin
					go_pay = 1'b1;
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				case (pos_q)
					2'd0:    kb = key_q[31:24];
					2'd1:    kb = key_q[23:16];
					2'd2:    kb = key_q[15:8];
					default: kb = key_q[7:0];
				endcase
				if (!mask_q) begin
					kb = 8'd0;
				end
				n_pos = pos_q + 2'd1;
				n_len = len_q - wsd_pkg::LEN_BITS'(1);
				last  = (len_q == wsd_pkg::LEN_BITS'(1));
				if (last) begin
					n_phase = wsd_pkg::PH_HDR0;
				end
				res_valid = 1'b1;
				res.data  = in_byte;
				res.key   = kb;
				res.kind  = wsd_pkg::KIND_PAYLOAD;
				res.mk    = mop_q;
				res.fe    = last;
				res.me    = last & fin_q;
			end
			wsd_pkg::PH_DROP: begin
			end
			default: begin
				n_hcnt = 3'd0;
				n_len  = '0;
				n_pos  = 2'd0;
				n_key  = 32'd0;
				n_mask = 1'b0;
				n_fin  = in_byte[7];
				if (op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_BINARY ||
				    op == wsd_pkg::OP_CLOSE || op == wsd_pkg::OP_PING ||
				    op == wsd_pkg::OP_PONG) begin
					n_mop   = op;
					n_phase = wsd_pkg::PH_HDR1;
				end else if (op == wsd_pkg::OP_CONT) begin
					n_phase = wsd_pkg::PH_HDR1;
				end else begin
					n_phase   = wsd_pkg::PH_DROP;
					res_valid = 1'b1;
					res.kind  = wsd_pkg::KIND_ERROR;
					res.mk    = op;
				end
			end
		endcase

		if (go_len) begin
			if (n_mask) begin
				n_phase = wsd_pkg::PH_KEY;
				n_hcnt  = 3'd3;
				n_key   = 32'd0;
			end else begin
				go_pay = 1'b1;
			end
		end
		if (go_pay) begin
			n_pos = 2'd0;
			if (n_len == '0) begin
				n_phase   = wsd_pkg::PH_HDR0;
				res_valid = 1'b1;
				res.kind  = wsd_pkg::KIND_EMPTY;
				res.mk    = n_mop;
				res.fe    = 1'b1;
				res.me    = n_fin;
			end else begin
				n_phase = wsd_pkg::PH_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_HDR0;
			hcnt_q  <= 3'd0;
			len_q   <= '0;
			pos_q   <= 2'd0;
			key_q   <= 32'd0;
			mask_q  <= 1'b0;
			fin_q   <= 1'b0;
			mop_q   <= 4'd0;
		end else if (take) begin
			phase_q <= n_phase;
			hcnt_q  <= n_hcnt;
			len_q   <= n_len;
			pos_q   <= n_pos;
			key_q   <= n_key;
			mask_q  <= n_mask;
			fin_q   <= n_fin;
			mop_q   <= n_mop;
		end
	end

	a_err_drops: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_valid && res.kind == wsd_pkg::KIND_ERROR |=> phase_q == wsd_pkg::PH_DROP)
		else $error("error result did not enter drop phase");

	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsd_pkg::PH_DROP && !restart |-> !res_valid)
		else $error("result produced while dropping");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsd_pkg::PH_PAYLOAD |-> len_q != '0)
		else $error("payload phase with zero remaining length");

endmodule

FILE: hw/rtl/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue: result queue
// Short FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
module wsd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsd_pkg::res_t     push_data,
	input  logic              pop,
	output logic              full,
	output logic              nonempty,
	output wsd_pkg::res_t     head
);

	wsd_pkg::res_t               mem [wsd_pkg::Q_DEPTH];
	logic [wsd_pkg::Q_AW-1:0]    wr_q, rd_q;
	logic [wsd_pkg::Q_CW-1:0]    cnt_q;

	assign full     = (cnt_q == wsd_pkg::Q_CW'(wsd_pkg::Q_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + wsd_pkg::Q_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + wsd_pkg::Q_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + wsd_pkg::Q_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - wsd_pkg::Q_CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from empty queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= wsd_pkg::Q_CW'(wsd_pkg::Q_DEPTH))
		else $error("queue count out of range");

endmodule

FILE: hw/rtl/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back: output stage
// Unmasks the queued byte and holds the result in the output register.
// ----------------------------------------------------------------------------
module wsd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              nonempty,
	input  wsd_pkg::res_t     head,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast,
	output logic [6:0]        m_tuser
);

	logic        vld_q;
	logic [7:0]  data_q;
	logic [1:0]  kind_q;
	logic [3:0]  mk_q;
	logic        fe_q;
	logic        me_q;

	assign pop      = nonempty && (!vld_q || m_tready);
	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tlast  = fe_q;
	assign m_tuser  = {me_q, mk_q, kind_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || m_tready) begin
			vld_q <= nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head.data ^ head.key;
			kind_q <= head.kind;
			mk_q   <= head.mk;
			fe_q   <= head.fe;
			me_q   <= head.me;
		end
	end

endmodule

FILE: hw/rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer: WebSocket receive-side frame parser
// Parses header, length and mask key from a byte stream and emits unmasked
// payload bytes, empty-frame markers and opcode errors.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock with no gaps while the output side keeps
// up. A byte's result reaches m_tvalid via the result queue and the output
// register: the header parser is combinational and writes the result queue
// as the byte is accepted, and the output register loads from the queue head.
// A four-entry result queue separates parser and output, so s_tready drops
// only once four results are waiting behind a stalled sink.
// A restart flag in s_tuser drops any partial frame; after an unknown opcode,
// bytes are dropped silently until the next restart.
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic [0:0]  s_tuser,   // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,   // frame_end
	output logic [6:0]  m_tuser    // [1:0] kind, [5:2] message_kind, [6] message_end
);

	logic           take, res_valid, q_full, q_nonempty, q_pop;
	wsd_pkg::res_t  res, q_head;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	wsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (s_tdata),
		.restart   (s_tuser[0]),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && res_valid),
		.push_data (res),
		.pop       (q_pop),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	wsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nonempty  (q_nonempty),
		.head      (q_head),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: WebSocket frame deframer
// Streams frames one byte per item into the deframer and predicts every
// result in step with the input. Frames cover all opcodes, fin, masking,
// 7-bit, 16-bit and 64-bit lengths and empty frames. Unknown opcodes,
// truncated frames and restarts are mixed in. Each result is checked field
// by field, in order. Both sides idle at random, with a long stretch where
// neither side idles.
// ----------------------------------------------------------------------------
module testbench;

	localparam int RANDOM_ITEMS   = 480;
	localparam int STALL_LIMIT    = 4000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int FORM_SHORT     = 0;
	localparam int FORM_EXT16     = 1;
	localparam int FORM_EXT64     = 2;
	localparam logic [3:0] BAD_OP_LOW  = 4'd3;
	localparam logic [3:0] BAD_OP_HIGH = 4'd15;
	localparam logic [3:0] LEGAL_OPS [6] = '{wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT,
		wsd_pkg::OP_BINARY, wsd_pkg::OP_CLOSE, wsd_pkg::OP_PING, wsd_pkg::OP_PONG};

	typedef struct {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [3:0] msg_kind;
		logic       frame_end;
		logic       msg_end;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [6:0]  m_tuser;

	// predicted parser state
	wsd_pkg::phase_t parse_at = wsd_pkg::PH_HDR0;
	logic [2:0]  hdr_left = '0;
	logic [63:0] plen = '0;
	logic [63:0] pos = '0;
	logic [31:0] key = '0;
	logic        masked = 1'b0;
	logic        fin = 1'b0;
	logic [3:0]  msg_op = wsd_pkg::OP_CONT;

	frame_result_t pending_results[$];
	frame_result_t got;

	bit steady = 1'b0;
	int fails = 0;
	int fed = 0;
	int dropped = 0;
	int restarts = 0;
	int n_payload = 0;
	int n_empty = 0;
	int n_error = 0;
	int idle_cycles = 0;
	int stall_left = 0;

	websocket_frame_deframer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void expect_result(input logic [7:0] b, input logic [1:0] kind,
		input logic [3:0] mk, input logic fe, input logic me);
		frame_result_t r;
		r.out_byte  = b;
		r.kind      = kind;
		r.msg_kind  = mk;
		r.frame_end = fe;
		r.msg_end   = me;
		pending_results.push_back(r);
	endfunction

	// header complete: empty frame gives a marker, else payload follows
	function automatic void header_done();
		pos = '0;
		if (plen == 0) begin
			parse_at = wsd_pkg::PH_HDR0;
			expect_result(8'h00, wsd_pkg::KIND_EMPTY, msg_op, 1'b1, fin);
		end else begin
			parse_at = wsd_pkg::PH_PAYLOAD;
		end
	endfunction

	function automatic void length_done();
		if (masked) begin
			parse_at = wsd_pkg::PH_KEY;
			hdr_left = 3'd3;
			key = '0;
		end else begin
			header_done();
		end
	endfunction

	// returns 0 for a byte dropped after an unknown opcode
	function automatic bit track_byte(input logic [7:0] b, input bit rs);
		wsd_pkg::phase_t ph;
		logic [3:0] op;
		logic [7:0] kb;
		ph = rs ? wsd_pkg::PH_HDR0 : parse_at;
		case (ph)
		wsd_pkg::PH_HDR1: begin
			masked = b[7];
			key = '0;
			plen = '0;
			if (b[6:0] == wsd_pkg::LEN_EXT16) begin
				parse_at = wsd_pkg::PH_EXTLEN;
				hdr_left = 3'd1;
			end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
				parse_at = wsd_pkg::PH_EXTLEN;
				hdr_left = 3'd7;
			end else begin
				plen = 64'(b[6:0]);
				length_done();
			end
		end
		wsd_pkg::PH_EXTLEN: begin
			plen = {plen[55:0], b};
			if (hdr_left != 0)
				hdr_left = hdr_left - 3'd1;
			else
				length_done();
		end
		wsd_pkg::PH_KEY: begin
			key = {key[23:0], b};
			if (hdr_left != 0)
				hdr_left = hdr_left - 3'd1;
			else
				header_done();
		end
		wsd_pkg::PH_PAYLOAD: begin
			kb = masked ? key[8 * (3 - pos[1:0]) +: 8] : 8'h00;
			pos = pos + 64'd1;
			if (pos == plen)
				parse_at = wsd_pkg::PH_HDR0;
			expect_result(b ^ kb, wsd_pkg::KIND_PAYLOAD, msg_op, pos == plen,
				pos == plen && fin);
		end
		wsd_pkg::PH_DROP: begin
			return 1'b0;
		end
		default: begin
			op = b[3:0];
			hdr_left = '0;
			plen = '0;
			pos = '0;
			key = '0;
			masked = 1'b0;
			fin = b[7];
			if (op inside {wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY, wsd_pkg::OP_CLOSE,
				wsd_pkg::OP_PING, wsd_pkg::OP_PONG}) begin
				msg_op = op;
			end else if (op != wsd_pkg::OP_CONT) begin
				parse_at = wsd_pkg::PH_DROP;
				expect_result(8'h00, wsd_pkg::KIND_ERROR, op, 1'b0, 1'b0);
				return 1'b1;
			end
			parse_at = wsd_pkg::PH_HDR1;
		end
		endcase
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit rs);
		while (!steady && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= rs;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (rs)
			restarts++;
		if (!track_byte(b, rs))
			dropped++;
		fed++;
	endtask

	// cut < 0 sends the whole frame, else only its first cut bytes
	task automatic send_frame(input logic [3:0] op, input bit fin_bit, input bit mask_bit,
		input logic [63:0] len, input int form, input bit rs, input int cut);
		logic [7:0] hdr[$];
		logic [63:0] k;
		int n;
		hdr.push_back({fin_bit, 3'($urandom), op});
		case (form)
		FORM_EXT16: begin
			hdr.push_back({mask_bit, wsd_pkg::LEN_EXT16});
			hdr.push_back(len[15:8]);
			hdr.push_back(len[7:0]);
		end
		FORM_EXT64: begin
			hdr.push_back({mask_bit, wsd_pkg::LEN_EXT64});
			for (int i = 7; i >= 0; i--)
				hdr.push_back(len[8 * i +: 8]);
		end
		default: begin
			hdr.push_back({mask_bit, len[6:0]});
		end
		endcase
		if (mask_bit)
			repeat (4) hdr.push_back(8'($urandom));
		n = 0;
		foreach (hdr[i]) begin
			if (cut >= 0 && n >= cut)
				return;
			send_byte(hdr[i], rs && i == 0);
			n++;
		end
		for (k = 0; k < len; k++) begin
			if (cut >= 0 && n >= cut)
				return;
			send_byte(8'($urandom), 1'b0);
			n++;
		end
	endtask

	task automatic test_empty_and_continuation();
		send_frame(wsd_pkg::OP_CONT, 1'b1, 1'b0, 64'd0, FORM_SHORT, 1'b0, -1);
		send_frame(wsd_pkg::OP_TEXT, 1'b0, 1'b1, 64'd1, FORM_SHORT, 1'b0, -1);
		send_frame(wsd_pkg::OP_CONT, 1'b1, 1'b0, 64'd1, FORM_SHORT, 1'b0, -1);
		send_frame(wsd_pkg::OP_BINARY, 1'b0, 1'b0, 64'd0, FORM_SHORT, 1'b1, -1);
	endtask

	task automatic test_extended_lengths();
		send_frame(wsd_pkg::OP_PONG, 1'b1, 1'b1, 64'd0, FORM_EXT16, 1'b0, -1);
		send_frame(wsd_pkg::OP_CLOSE, 1'b1, 1'b0, 64'd2, FORM_EXT64, 1'b0, -1);
		send_frame(wsd_pkg::OP_TEXT, 1'b0, 1'b1, '1, FORM_EXT64, 1'b0, 17);
	endtask

	task automatic test_restart();
		send_frame(wsd_pkg::OP_PING, 1'b1, 1'b0, 64'd0, FORM_SHORT, 1'b1, -1);
		send_frame(wsd_pkg::OP_BINARY, 1'b0, 1'b0, 64'hFFFF, FORM_EXT16, 1'b0, 3);
		send_frame(wsd_pkg::OP_CONT, 1'b1, 1'b1, 64'd2, FORM_SHORT, 1'b1, -1);
	endtask

	task automatic test_bad_opcodes();
		send_frame(BAD_OP_HIGH, 1'b1, 1'b0, 64'd2, FORM_SHORT, 1'b0, -1);
		send_frame(BAD_OP_LOW, 1'b0, 1'b0, 64'd0, FORM_SHORT, 1'b1, -1);
		send_frame(wsd_pkg::OP_TEXT, 1'b1, 1'b0, 64'd1, FORM_SHORT, 1'b1, -1);
	endtask

	// mostly well-formed frames; some unknown opcodes and truncated frames
	task automatic test_random_stream();
		int start;
		int r;
		int form;
		int rl;
		bit need_rs;
		logic [3:0] op;
		logic [63:0] len;
		start = fed;
		need_rs = 1'b0;
		steady = 1'b1;
		while (fed - start < RANDOM_ITEMS) begin
			if (fed - start >= RANDOM_ITEMS / 4)
				steady = 1'b0;
			r = $urandom_range(99);
			if (r < 8) begin
				do op = 4'($urandom); while (op inside {LEGAL_OPS});
				send_frame(op, 1'($urandom), 1'($urandom), 64'($urandom_range(5)),
					FORM_SHORT, need_rs || $urandom_range(1), -1);
				need_rs = $urandom_range(9) != 0;
			end else if (r < 16) begin
				form = $urandom_range(FORM_EXT64);
				case (form)
				FORM_EXT16: len = 64'($urandom_range(65535));
				FORM_EXT64: len = {$urandom, $urandom};
				default:    len = 64'($urandom_range(125));
				endcase
				send_frame(LEGAL_OPS[$urandom_range(5)], 1'($urandom), 1'($urandom), len,
					form, need_rs, $urandom_range(1, 16));
				need_rs = $urandom_range(9) != 0;
			end else begin
				rl = $urandom_range(99);
				if (rl < 70) begin
					form = FORM_SHORT;
					len = 64'($urandom_range(12));
				end else if (rl < 75) begin
					form = FORM_SHORT;
					len = 64'($urandom_range(125, 100));
				end else if (rl < 90) begin
					form = FORM_EXT16;
					len = 64'($urandom_range(4) == 0 ? $urandom_range(400) : $urandom_range(20));
				end else begin
					form = FORM_EXT64;
					len = 64'($urandom_range(20));
				end
				send_frame(LEGAL_OPS[$urandom_range(5)], 1'($urandom), 1'($urandom), len,
					form, need_rs || $urandom_range(3) == 0, -1);
				need_rs = 1'b0;
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!steady && $urandom_range(99) < 5) begin
			stall_left <= $urandom_range(9);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: out_byte %h kind %0d", m_tdata, m_tuser[1:0]);
				fails++;
			end else begin
				got = pending_results.pop_front();
				case (got.kind)
				wsd_pkg::KIND_PAYLOAD: n_payload++;
				wsd_pkg::KIND_EMPTY:   n_empty++;
				default:               n_error++;
				endcase
				if (m_tdata !== got.out_byte) begin
					$error("out_byte expected %h got %h", got.out_byte, m_tdata);
					fails++;
				end
				if (m_tuser[1:0] !== got.kind) begin
					$error("kind expected %0d got %0d", got.kind, m_tuser[1:0]);
					fails++;
				end
				if (m_tuser[5:2] !== got.msg_kind) begin
					$error("message_kind expected %0d got %0d", got.msg_kind, m_tuser[5:2]);
					fails++;
				end
				if (m_tlast !== got.frame_end) begin
					$error("frame_end expected %0d got %0d", got.frame_end, m_tlast);
					fails++;
				end
				if (m_tuser[6] !== got.msg_end) begin
					$error("message_end expected %0d got %0d", got.msg_end, m_tuser[6]);
					fails++;
				end
			end
		end
	end

	// counts cycles with work outstanding but no item moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| !(s_tvalid || pending_results.size() != 0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_continuation();
		test_extended_lengths();
		test_restart();
		test_bad_opcodes();
		test_random_stream();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("fed %0d bytes (%0d dropped after unknown opcodes) with %0d restarts",
			fed, dropped, restarts);
		$display("checked %0d payload bytes, %0d empty-frame markers, %0d opcode errors",
			n_payload, n_empty, n_error);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_front.sv
hw/rtl/wsd_queue.sv
hw/rtl/wsd_back.sv
hw/rtl/websocket_frame_deframer.sv
test/testbench.sv
